// File: rtl/c2ae_pkg.sv
// Shared types, constants and the arctangent table for the azimuth/elevation converter.
`default_nettype none
package c2ae_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned COORD_BITS_DEF   = 32;

  localparam int unsigned ZW = 26;                 // angle accumulator, degrees * 2^16
  localparam logic [15:0] Q7_RIGHT     = 16'd11520;
  localparam logic [15:0] Q7_HALF_TURN = 16'd23040;
  localparam logic signed [ZW-1:0] ANG_RIGHT = ZW'(90 * 65536);

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [14:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic        [31:0] length;
  } out_t;

  // operand signs for folding the first-quadrant angle
  typedef struct packed {
    logic neg_a;
    logic neg_b;
  } sign_t;

  localparam logic [22:0] ATAN_TAB [32] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
    23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2,
    23'd1, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0
  };

endpackage
`default_nettype wire

// File: rtl/c2ae_isqrt.sv
// Pipelined bit-per-stage integer square root of two radicands, with a side tag.
`default_nettype none
module c2ae_isqrt #(
  parameter int unsigned TAG_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [63:0]       rad0_i,
  input  wire logic [63:0]       rad1_i,
  input  wire logic [TAG_W-1:0]  tag_i,
  output logic                   valid_o,
  output logic [31:0]            root0_o,
  output logic [31:0]            root1_o,
  output logic [TAG_W-1:0]       tag_o
);
  import c2ae_pkg::*;

  logic [63:0]      n0 [33];
  logic [63:0]      r0 [33];
  logic [63:0]      n1 [33];
  logic [63:0]      r1 [33];
  logic [TAG_W-1:0] tg [33];
  logic             vl [33];

  assign n0[0] = rad0_i;
  assign n1[0] = rad1_i;
  assign r0[0] = '0;
  assign r1[0] = '0;
  assign tg[0] = tag_i;
  assign vl[0] = valid_i;

  for (genvar k = 0; k < 32; k++) begin : g_stage
    localparam logic [64:0] BIT = 65'd1 << (2 * (31 - k));
    logic [64:0] t0, t1;
    logic [63:0] n0_d, r0_d, n1_d, r1_d;
    logic [63:0] n0_q, r0_q, n1_q, r1_q;
    logic [TAG_W-1:0] tg_q;
    logic vl_q;

    always_comb begin
      t0 = {1'b0, r0[k]} + BIT;
      t1 = {1'b0, r1[k]} + BIT;
      if ({1'b0, n0[k]} >= t0) begin
        n0_d = 64'({1'b0, n0[k]} - t0);
        r0_d = 64'({1'b0, r0[k] >> 1} + BIT);
      end else begin
        n0_d = n0[k];
        r0_d = r0[k] >> 1;
      end
      if ({1'b0, n1[k]} >= t1) begin
        n1_d = 64'({1'b0, n1[k]} - t1);
        r1_d = 64'({1'b0, r1[k] >> 1} + BIT);
      end else begin
        n1_d = n1[k];
        r1_d = r1[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q <= 1'b0;
      end else if (en_i) begin
        vl_q <= vl[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n0_q <= n0_d;
        r0_q <= r0_d;
        n1_q <= n1_d;
        r1_q <= r1_d;
        tg_q <= tg[k];
      end
    end

    assign n0[k+1] = n0_q;
    assign r0[k+1] = r0_q;
    assign n1[k+1] = n1_q;
    assign r1[k+1] = r1_q;
    assign tg[k+1] = tg_q;
    assign vl[k+1] = vl_q;
  end

  assign valid_o = vl[32];
  assign root0_o = r0[32][31:0];
  assign root1_o = r1[32][31:0];
  assign tag_o   = tg[32];

endmodule
`default_nettype wire

// File: rtl/c2ae_cordic.sv
// Pipelined CORDIC vectoring: normalize, iterate, round and fold to a full-circle angle.
`default_nettype none
module c2ae_cordic #(
  parameter int unsigned CORDIC_STEPS = c2ae_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned COORD_BITS   = c2ae_pkg::COORD_BITS_DEF,
  parameter int unsigned TAG_W        = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [32:0]       a_mag_i,
  input  wire logic [32:0]       b_mag_i,
  input  wire c2ae_pkg::sign_t   sign_i,
  input  wire logic [TAG_W-1:0]  tag_i,
  output logic                   valid_o,
  output logic signed [15:0]     angle_o,
  output logic [TAG_W-1:0]       tag_o
);
  import c2ae_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned NI  = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int unsigned NW  = 33 + CB;
  localparam logic [6:0]  TGT = 7'(CB - 4);

  // stage 1: register operands and leading-one position
  logic [32:0] am_q, bm_q, m;
  logic [5:0]  pos_d, pos_q;
  logic        az_q, bz_q, v1_q;
  sign_t       s1_q;
  logic [TAG_W-1:0] t1_q;

  always_comb begin
    m = a_mag_i | b_mag_i;
    pos_d = '0;
    for (int i = 0; i < 33; i++) begin
      if (m[i]) pos_d = 6'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q  <= a_mag_i;
      bm_q  <= b_mag_i;
      pos_q <= pos_d;
      az_q  <= (a_mag_i == '0);
      bz_q  <= (b_mag_i == '0);
      s1_q  <= sign_i;
      t1_q  <= tag_i;
    end
  end

  // stage 2: common shift into [2^(CB-4), 2^(CB-3))
  logic [NW-1:0] wa, wb;
  logic [6:0]    sh;
  logic [CB-1:0] a_sh, b_sh;

  always_comb begin
    wa = NW'(am_q);
    wb = NW'(bm_q);
    if ({1'b0, pos_q} > TGT) begin
      sh   = {1'b0, pos_q} - TGT;
      a_sh = CB'(wa >> sh);
      b_sh = CB'(wb >> sh);
    end else begin
      sh   = TGT - {1'b0, pos_q};
      a_sh = CB'(wa << sh);
      b_sh = CB'(wb << sh);
    end
  end

  logic signed [CB-1:0] ax [NI+1];
  logic signed [CB-1:0] bx [NI+1];
  logic signed [ZW-1:0] zx [NI+1];
  logic                 vx [NI+1];
  logic                 azx [NI+1];
  logic                 bzx [NI+1];
  sign_t                sx [NI+1];
  logic [TAG_W-1:0]     tx [NI+1];

  logic signed [CB-1:0] a2_q, b2_q;
  logic az2_q, bz2_q, v2_q;
  sign_t s2_q;
  logic [TAG_W-1:0] t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q  <= a_sh;
      b2_q  <= b_sh;
      az2_q <= az_q;
      bz2_q <= bz_q;
      s2_q  <= s1_q;
      t2_q  <= t1_q;
    end
  end

  assign ax[0]  = a2_q;
  assign bx[0]  = b2_q;
  assign zx[0]  = '0;
  assign vx[0]  = v2_q;
  assign azx[0] = az2_q;
  assign bzx[0] = bz2_q;
  assign sx[0]  = s2_q;
  assign tx[0]  = t2_q;

  // one rotation per stage
  for (genvar i = 0; i < NI; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[i]);
    logic signed [CB-1:0] a_q, b_q;
    logic signed [ZW-1:0] z_q;
    logic v_q, az_q2, bz_q2;
    sign_t s_q;
    logic [TAG_W-1:0] t_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= vx[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!bx[i][CB-1]) begin
          a_q <= ax[i] + (bx[i] >>> i);
          b_q <= bx[i] - (ax[i] >>> i);
          z_q <= zx[i] + ANG;
        end else begin
          a_q <= ax[i] - (bx[i] >>> i);
          b_q <= bx[i] + (ax[i] >>> i);
          z_q <= zx[i] - ANG;
        end
        az_q2 <= azx[i];
        bz_q2 <= bzx[i];
        s_q   <= sx[i];
        t_q   <= tx[i];
      end
    end

    assign ax[i+1]  = a_q;
    assign bx[i+1]  = b_q;
    assign zx[i+1]  = z_q;
    assign vx[i+1]  = v_q;
    assign azx[i+1] = az_q2;
    assign bzx[i+1] = bz_q2;
    assign sx[i+1]  = s_q;
    assign tx[i+1]  = t_q;
  end

  // final stage: clamp, round to Q9.7, handle axes, fold to full circle
  logic signed [ZW-1:0] zc, zr;
  logic [15:0]          q1;
  logic signed [15:0]   q_d, q_q;
  logic                 vo_q;
  logic [TAG_W-1:0]     to_q;

  always_comb begin
    zc = zx[NI];
    if (zc < 0) zc = '0;
    if (zc > ANG_RIGHT) zc = ANG_RIGHT;
    zr = zc + ZW'(256);
    if (bzx[NI]) begin
      q1 = '0;
    end else if (azx[NI]) begin
      q1 = Q7_RIGHT;
    end else begin
      q1 = {2'b00, zr[22:9]};
    end
    if (sx[NI].neg_a) q1 = Q7_HALF_TURN - q1;
    q_d = sx[NI].neg_b ? -$signed(q1) : $signed(q1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vx[NI];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q  <= q_d;
      to_q <= tx[NI];
    end
  end

  assign valid_o = vo_q;
  assign angle_o = q_q;
  assign tag_o   = to_q;

endmodule
`default_nettype wire

// File: rtl/cartesian_to_azimuth_elevation.sv
// Top level: squares, sums, square roots and two CORDIC lanes for pitch, yaw and length.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid_i/in_ready_o   | c2ae_pkg::in_t  (vec_x, vec_y, vec_z)
//   out     | output    | out_valid_o/out_ready_i | c2ae_pkg::out_t (pitch_deg, yaw_deg, length)
//
// One word is taken per cycle unless the output stalls; the pipeline includes the
// 32-stage square root and one stage per CORDIC rotation (CORDIC_STEPS, at most 32).
// Reset clears the valid bits only; no clearing pass.
// A stall on the output freezes every stage at once; nothing is lost or repeated.
`default_nettype none
module cartesian_to_azimuth_elevation #(
  parameter int unsigned CORDIC_STEPS = c2ae_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned COORD_BITS   = c2ae_pkg::COORD_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire c2ae_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output c2ae_pkg::out_t       out_data_o
);
  import c2ae_pkg::*;

  localparam int unsigned TAG_W = 99;  // xmag, zmag, ymag, neg y, pos z, pos x

  logic en;
  logic vo_q;
  assign en         = !vo_q || out_ready_i;
  assign in_ready_o = en;

  // stage 0: magnitudes
  logic        v0_q;
  logic [31:0] xm_q, ym_q, zm_q;
  logic        xpos_q, zpos_q, yneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xm_q   <= in_data_i.vec_x[31] ? 32'(-in_data_i.vec_x) : in_data_i.vec_x;
      ym_q   <= in_data_i.vec_y[31] ? 32'(-in_data_i.vec_y) : in_data_i.vec_y;
      zm_q   <= in_data_i.vec_z[31] ? 32'(-in_data_i.vec_z) : in_data_i.vec_z;
      xpos_q <= !in_data_i.vec_x[31] && (in_data_i.vec_x != '0);
      zpos_q <= !in_data_i.vec_z[31] && (in_data_i.vec_z != '0);
      yneg_q <= in_data_i.vec_y[31];
    end
  end

  // stage 1: squares
  logic        v1_q;
  logic [63:0] xx_q, yy_q, zz_q;
  logic [TAG_W-1:0] t1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q <= xm_q * xm_q;
      yy_q <= ym_q * ym_q;
      zz_q <= zm_q * zm_q;
      t1_q <= {xm_q, zm_q, ym_q, yneg_q, zpos_q, xpos_q};
    end
  end

  // stage 2: sums
  logic        v2_q;
  logic [63:0] sxz_q, sall_q;
  logic [TAG_W-1:0] t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sxz_q  <= xx_q + zz_q;
      sall_q <= xx_q + yy_q + zz_q;
      t2_q   <= t1_q;
    end
  end

  logic             vs;
  logic [31:0]      d_root, len_root;
  logic [TAG_W-1:0] ts;

  c2ae_isqrt #(.TAG_W(TAG_W)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad0_i  (sxz_q),
    .rad1_i  (sall_q),
    .tag_i   (t2_q),
    .valid_o (vs),
    .root0_o (d_root),
    .root1_o (len_root),
    .tag_o   (ts)
  );

  logic [31:0] s_xm, s_zm, s_ym;
  logic        s_yneg, s_zpos, s_xpos;
  sign_t       pitch_sign, yaw_sign;
  assign {s_xm, s_zm, s_ym, s_yneg, s_zpos, s_xpos} = ts;
  assign pitch_sign = '{neg_a: 1'b0, neg_b: s_yneg};
  assign yaw_sign   = '{neg_a: s_zpos, neg_b: s_xpos};

  logic               vp, vy;
  logic signed [15:0] pitch_q7, yaw_q7;
  logic [15:0]        len_hi, len_lo;

  // the length rides along as two halves, one in each lane
  c2ae_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_BITS   (COORD_BITS),
    .TAG_W        (16)
  ) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vs),
    .a_mag_i ({1'b0, d_root}),
    .b_mag_i ({1'b0, s_ym}),
    .sign_i  (pitch_sign),
    .tag_i   (len_root[31:16]),
    .valid_o (vp),
    .angle_o (pitch_q7),
    .tag_o   (len_hi)
  );

  c2ae_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_BITS   (COORD_BITS),
    .TAG_W        (16)
  ) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vs),
    .a_mag_i ({1'b0, s_zm}),
    .b_mag_i ({1'b0, s_xm}),
    .sign_i  (yaw_sign),
    .tag_i   (len_root[15:0]),
    .valid_o (vy),
    .angle_o (yaw_q7),
    .tag_o   (len_lo)
  );

  // output register
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vp && vy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.pitch_deg <= pitch_q7[14:0];
      out_q.yaw_deg   <= yaw_q7;
      out_q.length    <= {len_hi, len_lo};
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.yaw_deg <= 16'sd23040 && out_data_o.yaw_deg >= -16'sd23040))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pitch_deg <= 15'sd11520 && out_data_o.pitch_deg >= -15'sd11520))
    else $error("pitch out of range");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vp == vy)
    else $error("pitch and yaw lanes out of step");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(out_data_o))
    else $error("output word changed during stall");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for the azimuth/elevation converter: directed and random vectors, stalls, scoreboard.
module tb_top;
  import c2ae_pkg::*;

  localparam int unsigned STEPS   = CORDIC_STEPS_DEF;
  localparam int unsigned CBITS   = COORD_BITS_DEF;
  localparam int unsigned LATENCY = STEPS + 39;
  localparam int unsigned WDOG    = 20000;

  localparam longint ATAN_DEG [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  cartesian_to_azimuth_elevation dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  out_t expected_words[$];
  int   n_errors;
  int   idle_cycles;
  int   hold_cycles;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint quadrant_angle(longint unsigned am, longint unsigned bm);
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned m;
    longint a;
    longint b;
    longint acc;
    longint da;
    longint db;
    hi = 64'd1 << (CBITS - 3);
    lo = 64'd1 << (CBITS - 4);
    acc = 0;
    if (bm == 0) return 0;
    if (am == 0) return 11520;
    m = (am > bm) ? am : bm;
    while (m >= hi) begin
      am = am >> 1; bm = bm >> 1; m = m >> 1;
    end
    while (m < lo) begin
      am = am << 1; bm = bm << 1; m = m << 1;
    end
    a = longint'(am);
    b = longint'(bm);
    for (int i = 0; i < STEPS && i < 32; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a = a + da; b = b - db; acc = acc + ATAN_DEG[i];
      end else begin
        a = a - da; b = b + db; acc = acc - ATAN_DEG[i];
      end
    end
    if (acc < 0) acc = 0;
    if (acc > 90 * 65536) acc = 90 * 65536;
    return (acc + 256) >>> 9;
  endfunction

  function automatic longint angle_deg(longint b, longint a);
    longint q;
    q = quadrant_angle((a < 0) ? -a : a, (b < 0) ? -b : b);
    if (a < 0) q = 23040 - q;
    if (b < 0) q = -q;
    return q;
  endfunction

  function automatic out_t spherical_of(in_t v);
    longint x;
    longint y;
    longint z;
    longint unsigned xx;
    longint unsigned yy;
    longint unsigned zz;
    longint unsigned horiz;
    out_t r;
    x = longint'(v.vec_x);
    y = longint'(v.vec_y);
    z = longint'(v.vec_z);
    xx = longint'(x * x);
    yy = longint'(y * y);
    zz = longint'(z * z);
    horiz = int_sqrt(xx + zz);
    r.pitch_deg = 15'(angle_deg(y, longint'(horiz)));
    r.yaw_deg   = 16'(angle_deg(-x, -z));
    r.length    = 32'(int_sqrt(xx + yy + zz));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // hold valid and payload until the word is taken; drop valid only for a gap
  task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit no_gap = 0);
    in_t w;
    int gap;
    w.vec_x = x;
    w.vec_y = y;
    w.vec_z = z;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(spherical_of(w));
  endtask

  // receiver: random stall per word, or a long hold when requested
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_data.pitch_deg !== want.pitch_deg)
          report_mismatch("pitch_deg", out_data.pitch_deg, want.pitch_deg);
        if (out_data.yaw_deg !== want.yaw_deg)
          report_mismatch("yaw_deg", out_data.yaw_deg, want.yaw_deg);
        if (out_data.length !== want.length)
          report_mismatch("length", out_data.length, want.length);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WDOG);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      4: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic test_axes_and_extremes();
    logic [31:0] vals [6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000,
                              32'h7fff_ffff, 32'h0001_0000};
    send_word(0, 0, 0);
    send_word(0, 0, 32'h0001_0000);  // straight behind
    send_word(0, 0, 32'hffff_0000);  // straight ahead
    send_word(32'h0001_0000, 0, 0);
    send_word(32'hffff_0000, 0, 0);
    send_word(0, 32'h0001_0000, 0);  // straight up, x = z = 0
    send_word(0, 32'hffff_0000, 0);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    for (int i = 0; i < 12; i++)
      send_word(vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)],
                vals[$urandom_range(0, 5)]);
  endtask

  task automatic test_random_vectors(int count);
    for (int i = 0; i < count; i++)
      send_word(rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 120; i++)
      send_word(rand_coord(), rand_coord(), rand_coord(), 1);
  endtask

  task automatic test_full_rate();
    for (int i = 0; i < 60; i++)
      send_word($urandom, $urandom, $urandom, 1);
  endtask

  initial begin
    int tail;
    n_errors = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_axes_and_extremes();
    test_output_backpressure();
    test_random_vectors(820);
    test_full_rate();
    in_valid <= 1'b0;
    tail = 0;
    while (expected_words.size() != 0 && tail < 100000) begin
      @(posedge clk);
      tail++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (n_errors == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
